>>> rtl/mips64_subset_execute_unit_macros.svh
// Assertion helpers; clk and rst_n are taken from the enclosing module.
`ifndef MIPS64_SUBSET_EXECUTE_UNIT_MACROS_SVH
`define MIPS64_SUBSET_EXECUTE_UNIT_MACROS_SVH

// Same-cycle implication.
`define M64X_ASSERT_IMP(label, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error(msg);

// Next-cycle implication.
`define M64X_ASSERT_NXT(label, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error(msg);

`endif

>>> rtl/m64x_pkg.sv
package m64x_pkg;

    localparam logic [2:0] FUNC_EXEC = 3'd0;
    localparam logic [2:0] FUNC_WREG = 3'd1;
    localparam logic [2:0] FUNC_RREG = 3'd2;
    localparam logic [2:0] FUNC_WMEM = 3'd3;
    localparam logic [2:0] FUNC_RMEM = 3'd4;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_BADOP  = 3'd1;
    localparam logic [2:0] ST_BADFN  = 3'd2;
    localparam logic [2:0] ST_LOAD   = 3'd3;
    localparam logic [2:0] ST_STORE  = 3'd4;
    localparam logic [2:0] ST_NOEXEC = 3'd5;
    localparam logic [2:0] ST_HALTED = 3'd6;

    localparam logic [5:0] OP_SPECIAL = 6'b000000;
    localparam logic [5:0] OP_ADDIU   = 6'b001001;
    localparam logic [5:0] OP_LUI     = 6'b001111;
    localparam logic [5:0] OP_LW      = 6'b100011;
    localparam logic [5:0] OP_SW      = 6'b101011;
    localparam logic [5:0] FN_AND     = 6'b100100;
    localparam logic [5:0] FN_OR      = 6'b100101;

    localparam logic [5:0] PC_INDEX   = 6'd32;

    typedef enum logic [1:0] {
        RSEL_RS,
        RSEL_RT,
        RSEL_IDX
    } rsel_t;

    typedef enum logic [2:0] {
        WSEL_LUI,
        WSEL_ADDIU,
        WSEL_OR,
        WSEL_AND,
        WSEL_LOAD,
        WSEL_ITEM
    } wsel_t;

    typedef enum logic [1:0] {
        RV_ZERO,
        RV_REG,
        RV_PC,
        RV_MEM
    } rv_sel_t;

    typedef struct packed {
        logic       take;
        logic       clr_r0;
        logic       rf_rd;
        rsel_t      rf_rsel;
        logic       rf_wr;
        wsel_t      rf_wsel;
        logic       cap_a;
        logic       cap_addr;
        logic       cap_b;
        logic       mem_rd;
        logic       mem_wr;
        logic       mem_word;
        logic [1:0] byte_sel;
        logic       shift_in;
        logic       pc_inc;
        logic       pc_wr;
        logic       fault;
        logic [2:0] fault_code;
        logic       res_ld;
        logic [2:0] res_code;
        rv_sel_t    res_rv;
    } dp_cmd_t;

    typedef struct packed {
        logic [2:0] func;
        logic       halted;
        logic       exec_ok;
        logic       op_lui;
        logic       op_addiu;
        logic       op_special;
        logic       op_lw;
        logic       op_sw;
        logic       fn_or;
        logic       fn_and;
        logic       idx_rf;
        logic       idx_pc;
        logic       maddr_ok;
        logic       word_fits;
    } dp_status_t;

endpackage

>>> rtl/m64x_datapath.sv
module m64x_datapath
    import m64x_pkg::*;
#(
    parameter int MEM_BYTES = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  dp_cmd_t     cmd,
    output dp_status_t  st,
    input  logic [2:0]  func,
    input  logic [31:0] instr,
    input  logic        exec_ok,
    input  logic [5:0]  reg_index,
    input  logic [11:0] mem_addr,
    input  logic [63:0] write_value,
    output logic [2:0]  status,
    output logic [63:0] read_value,
    output logic [63:0] pc_out
);

    localparam int AW = $clog2(MEM_BYTES);

    logic [2:0]  func_reg;
    logic [31:0] instr_reg;
    logic        exec_ok_reg;
    logic [5:0]  idx_reg;
    logic [11:0] maddr_reg;
    logic [63:0] wval_reg;

    logic [63:0] pc_reg;
    logic [2:0]  exit_code_reg;

    logic [63:0] rf_mem [32];
    logic [31:0] rf_valid_reg;
    logic [31:0] rf_valid_next;
    logic [63:0] rf_rdata_reg;
    logic        rf_rvalid_reg;

    logic [7:0]  dmem [MEM_BYTES];
    logic [7:0]  mem_rdata_reg;

    logic [63:0] a_reg;
    logic [31:0] b_reg;
    logic [63:0] addr_reg;
    logic [23:0] word_reg;

    logic [2:0]  status_reg;
    logic [63:0] read_value_reg;
    logic [63:0] pc_out_reg;

    logic [4:0]  rs;
    logic [4:0]  rt;
    logic [4:0]  rd;
    logic [15:0] imm;
    logic [63:0] imm_sx;
    logic [63:0] rf_rdata;
    logic [31:0] sum32;
    logic [31:0] load32;
    logic [4:0]  rf_raddr;
    logic [4:0]  rf_waddr;
    logic [63:0] rf_wdata;
    logic        rvalid_next;
    logic [63:0] maddr_ext;
    logic [AW-1:0] dmem_addr;
    logic [7:0]  dmem_wdata;

    assign rs       = instr_reg[25:21];
    assign rt       = instr_reg[20:16];
    assign rd       = instr_reg[15:11];
    assign imm      = instr_reg[15:0];
    assign imm_sx   = {{48{imm[15]}}, imm};
    assign rf_rdata = rf_rvalid_reg ? rf_rdata_reg : 64'd0;
    assign sum32    = rf_rdata[31:0] + {{16{imm[15]}}, imm};
    assign load32   = {word_reg, mem_rdata_reg};
    assign maddr_ext = 64'(maddr_reg);

    assign st.func       = func_reg;
    assign st.halted     = (exit_code_reg != ST_OK);
    assign st.exec_ok    = exec_ok_reg;
    assign st.op_lui     = (instr_reg[31:26] == OP_LUI);
    assign st.op_addiu   = (instr_reg[31:26] == OP_ADDIU);
    assign st.op_special = (instr_reg[31:26] == OP_SPECIAL);
    assign st.op_lw      = (instr_reg[31:26] == OP_LW);
    assign st.op_sw      = (instr_reg[31:26] == OP_SW);
    assign st.fn_or      = (instr_reg[5:0] == FN_OR);
    assign st.fn_and     = (instr_reg[5:0] == FN_AND);
    assign st.idx_rf     = (idx_reg < PC_INDEX);
    assign st.idx_pc     = (idx_reg == PC_INDEX);
    assign st.maddr_ok   = (maddr_ext < 64'(MEM_BYTES));
    assign st.word_fits  = (addr_reg <= 64'(MEM_BYTES - 4));

    always_comb
    begin
        case (cmd.rf_rsel)
            RSEL_RS:  rf_raddr = rs;
            RSEL_RT:  rf_raddr = rt;
            default:  rf_raddr = idx_reg[4:0];
        endcase
    end

    always_comb
    begin
        case (cmd.rf_wsel)
            WSEL_LUI:
            begin
                rf_waddr = rt;
                rf_wdata = {{32{imm[15]}}, imm, 16'd0};
            end
            WSEL_ADDIU:
            begin
                rf_waddr = rt;
                rf_wdata = {{32{sum32[31]}}, sum32};
            end
            WSEL_OR:
            begin
                rf_waddr = rd;
                rf_wdata = a_reg | rf_rdata;
            end
            WSEL_AND:
            begin
                rf_waddr = rd;
                rf_wdata = a_reg & rf_rdata;
            end
            WSEL_LOAD:
            begin
                rf_waddr = rt;
                rf_wdata = {{32{load32[31]}}, load32};
            end
            default:
            begin
                rf_waddr = idx_reg[4:0];
                rf_wdata = wval_reg;
            end
        endcase
    end

    // R0 cleared this cycle must read as zero
    assign rvalid_next = rf_valid_reg[rf_raddr] && !(cmd.clr_r0 && rf_raddr == 5'd0);

    always_comb
    begin
        rf_valid_next = rf_valid_reg;
        if (cmd.clr_r0)
        begin
            rf_valid_next[0] = 1'b0;
        end
        if (cmd.rf_wr)
        begin
            rf_valid_next[rf_waddr] = 1'b1;
        end
    end

    always_comb
    begin
        if (cmd.mem_word)
        begin
            dmem_addr = addr_reg[AW-1:0] + AW'(cmd.byte_sel);
        end
        else
        begin
            dmem_addr = maddr_ext[AW-1:0];
        end
        case (cmd.byte_sel)
            2'd0:    dmem_wdata = cmd.mem_word ? b_reg[31:24] : wval_reg[7:0];
            2'd1:    dmem_wdata = b_reg[23:16];
            2'd2:    dmem_wdata = b_reg[15:8];
            default: dmem_wdata = b_reg[7:0];
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rf_wr)
        begin
            rf_mem[rf_waddr] <= rf_wdata;
        end
        if (cmd.rf_rd)
        begin
            rf_rdata_reg <= rf_mem[rf_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mem_wr)
        begin
            dmem[dmem_addr] <= dmem_wdata;
        end
        if (cmd.mem_rd)
        begin
            mem_rdata_reg <= dmem[dmem_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= 64'd0;
            exit_code_reg <= ST_OK;
            rf_valid_reg  <= 32'd0;
            rf_rvalid_reg <= 1'b0;
        end
        else
        begin
            rf_valid_reg <= rf_valid_next;
            if (cmd.rf_rd)
            begin
                rf_rvalid_reg <= rvalid_next;
            end
            if (cmd.pc_inc)
            begin
                pc_reg <= pc_reg + 64'd4;
            end
            else if (cmd.pc_wr)
            begin
                pc_reg <= wval_reg;
            end
            if (cmd.fault)
            begin
                exit_code_reg <= cmd.fault_code;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            func_reg    <= func;
            instr_reg   <= instr;
            exec_ok_reg <= exec_ok;
            idx_reg     <= reg_index;
            maddr_reg   <= mem_addr;
            wval_reg    <= write_value;
        end
        if (cmd.cap_a)
        begin
            a_reg <= rf_rdata;
        end
        if (cmd.cap_addr)
        begin
            addr_reg <= rf_rdata + imm_sx;
        end
        if (cmd.cap_b)
        begin
            b_reg <= rf_rdata[31:0];
        end
        if (cmd.shift_in)
        begin
            word_reg <= {word_reg[15:0], mem_rdata_reg};
        end
        if (cmd.res_ld)
        begin
            status_reg <= cmd.res_code;
            pc_out_reg <= pc_reg;
            case (cmd.res_rv)
                RV_REG:  read_value_reg <= rf_rdata;
                RV_PC:   read_value_reg <= pc_reg;
                RV_MEM:  read_value_reg <= {56'd0, mem_rdata_reg};
                default: read_value_reg <= 64'd0;
            endcase
        end
    end

    assign status     = status_reg;
    assign read_value = read_value_reg;
    assign pc_out     = pc_out_reg;

endmodule

>>> rtl/m64x_ctrl.sv
module m64x_ctrl
    import m64x_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  dp_status_t st,
    output dp_cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DEC,
        S_RS,
        S_RT,
        S_CHK,
        S_LD,
        S_LDW,
        S_ST,
        S_DONE
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] cnt_reg, cnt_next;
    logic [2:0] code_reg, code_next;
    rv_sel_t    rv_reg, rv_next;
    logic       out_valid_reg, out_valid_next;

    always_comb
    begin
        cmd            = '0;
        cmd.rf_rsel    = RSEL_RS;
        cmd.rf_wsel    = WSEL_ITEM;
        cmd.res_rv     = RV_ZERO;
        cmd.byte_sel   = cnt_reg;
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        code_next      = code_reg;
        rv_next        = rv_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take   = 1'b1;
                    code_next  = ST_OK;
                    rv_next    = RV_ZERO;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                state_next = S_DONE;
                case (st.func)
                    FUNC_EXEC:
                    begin
                        if (st.halted)
                        begin
                            code_next = ST_HALTED;
                        end
                        else
                        begin
                            cmd.clr_r0 = 1'b1;
                            if (!st.exec_ok)
                            begin
                                cmd.fault      = 1'b1;
                                cmd.fault_code = ST_NOEXEC;
                                code_next      = ST_NOEXEC;
                            end
                            else if (st.op_lui)
                            begin
                                cmd.rf_wr   = 1'b1;
                                cmd.rf_wsel = WSEL_LUI;
                                cmd.pc_inc  = 1'b1;
                            end
                            else if (st.op_addiu || st.op_lw || st.op_sw ||
                                     (st.op_special && (st.fn_or || st.fn_and)))
                            begin
                                cmd.rf_rd   = 1'b1;
                                cmd.rf_rsel = RSEL_RS;
                                state_next  = S_RS;
                            end
                            else if (st.op_special)
                            begin
                                cmd.fault      = 1'b1;
                                cmd.fault_code = ST_BADFN;
                                code_next      = ST_BADFN;
                            end
                            else
                            begin
                                cmd.fault      = 1'b1;
                                cmd.fault_code = ST_BADOP;
                                code_next      = ST_BADOP;
                            end
                        end
                    end
                    FUNC_WREG:
                    begin
                        cmd.rf_wr   = st.idx_rf;
                        cmd.rf_wsel = WSEL_ITEM;
                        cmd.pc_wr   = st.idx_pc;
                    end
                    FUNC_RREG:
                    begin
                        if (st.idx_rf)
                        begin
                            cmd.rf_rd   = 1'b1;
                            cmd.rf_rsel = RSEL_IDX;
                            rv_next     = RV_REG;
                        end
                        else if (st.idx_pc)
                        begin
                            rv_next = RV_PC;
                        end
                    end
                    FUNC_WMEM:
                    begin
                        cmd.mem_wr = st.maddr_ok;
                    end
                    FUNC_RMEM:
                    begin
                        if (st.maddr_ok)
                        begin
                            cmd.mem_rd = 1'b1;
                            rv_next    = RV_MEM;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_RS:
            begin
                if (st.op_addiu)
                begin
                    cmd.rf_wr   = 1'b1;
                    cmd.rf_wsel = WSEL_ADDIU;
                    cmd.pc_inc  = 1'b1;
                    state_next  = S_DONE;
                end
                else if (st.op_lw)
                begin
                    cmd.cap_addr = 1'b1;
                    state_next   = S_CHK;
                end
                else
                begin
                    cmd.cap_a    = st.op_special;
                    cmd.cap_addr = st.op_sw;
                    cmd.rf_rd    = 1'b1;
                    cmd.rf_rsel  = RSEL_RT;
                    state_next   = S_RT;
                end
            end
            S_RT:
            begin
                if (st.op_sw)
                begin
                    cmd.cap_b  = 1'b1;
                    state_next = S_CHK;
                end
                else
                begin
                    cmd.rf_wr   = 1'b1;
                    cmd.rf_wsel = st.fn_or ? WSEL_OR : WSEL_AND;
                    cmd.pc_inc  = 1'b1;
                    state_next  = S_DONE;
                end
            end
            S_CHK:
            begin
                cnt_next = 2'd0;
                if (!st.word_fits)
                begin
                    cmd.fault      = 1'b1;
                    cmd.fault_code = st.op_lw ? ST_LOAD : ST_STORE;
                    code_next      = st.op_lw ? ST_LOAD : ST_STORE;
                    state_next     = S_DONE;
                end
                else
                begin
                    state_next = st.op_lw ? S_LD : S_ST;
                end
            end
            S_LD:
            begin
                cmd.mem_rd   = 1'b1;
                cmd.mem_word = 1'b1;
                cmd.shift_in = (cnt_reg != 2'd0);
                cnt_next     = cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                begin
                    state_next = S_LDW;
                end
            end
            S_LDW:
            begin
                cmd.rf_wr   = 1'b1;
                cmd.rf_wsel = WSEL_LOAD;
                cmd.pc_inc  = 1'b1;
                state_next  = S_DONE;
            end
            S_ST:
            begin
                cmd.mem_wr   = 1'b1;
                cmd.mem_word = 1'b1;
                cnt_next     = cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                begin
                    cmd.pc_inc = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                cmd.res_code = code_reg;
                cmd.res_rv   = rv_reg;
                if (!out_valid_reg || out_ready)
                begin
                    cmd.res_ld = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cmd.res_ld)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= 2'd0;
            code_reg      <= ST_OK;
            rv_reg        <= RV_ZERO;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            code_reg      <= code_next;
            rv_reg        <= rv_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

>>> rtl/mips64_subset_execute_unit.sv
// Execute unit for a big-endian MIPS64 subset (LUI, ADDIU, OR, AND, LW, SW).
// Input channel: in_valid/in_ready carry one transaction per item: func
// selects execute, register write/read (index 32 is the PC) or memory byte
// write/read. Output channel: out_valid/out_ready carry one transaction per
// item with status, read_value and pc_out.
// After accept the controller decodes; register and memory accesses, halted
// executes, LUI and faults decoded up front then finish. ADDIU adds an rs
// read, OR/AND rs and rt reads, LW an rs read, a bounds check, byte reads
// and a writeback, SW rs and rt reads, the check and byte writes; a word
// access outside memory faults at the check. One transaction is in flight at
// a time, on the single-port register file (rs then rt) and the byte-wide
// data memory port that moves one byte of a word per cycle.
// The finished result sits in an output register, so the next transaction
// is accepted while it waits; if out_ready stays low the unit holds the
// following result internally and stops accepting until the slot frees.
// Reset clears the registers (via valid bits), the PC and the exit code at
// once; no clearing pass is needed. Data memory is undefined until written.
`include "mips64_subset_execute_unit_macros.svh"

module mips64_subset_execute_unit
    import m64x_pkg::*;
#(
    parameter int MEM_BYTES = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  func,
    input  logic [31:0] instr,
    input  logic        exec_ok,
    input  logic [5:0]  reg_index,
    input  logic [11:0] mem_addr,
    input  logic [63:0] write_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [63:0] read_value,
    output logic [63:0] pc_out
);

    dp_cmd_t    cmd;
    dp_status_t st;

    m64x_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .st        (st),
        .cmd       (cmd)
    );

    m64x_datapath #(
        .MEM_BYTES (MEM_BYTES)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .st          (st),
        .func        (func),
        .instr       (instr),
        .exec_ok     (exec_ok),
        .reg_index   (reg_index),
        .mem_addr    (mem_addr),
        .write_value (write_value),
        .status      (status),
        .read_value  (read_value),
        .pc_out      (pc_out)
    );

    `M64X_ASSERT_IMP(a_take_hs, cmd.take, in_valid && in_ready, "take without handshake")
    `M64X_ASSERT_NXT(a_take_busy, cmd.take, !in_ready, "accepting while busy")
    `M64X_ASSERT_IMP(a_res_slot, cmd.res_ld, !out_valid || out_ready, "result overwritten")
    `M64X_ASSERT_IMP(a_fault_quiet, cmd.fault, !cmd.pc_inc && !cmd.rf_wr && !cmd.mem_wr,
                     "fault changed state")

endmodule

>>> tb/m64x_exec_check.sv
module m64x_exec_check
    import m64x_pkg::*;
#(
    parameter int MEM_BYTES = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [2:0]  func,
    input  logic [31:0] instr,
    input  logic        exec_ok,
    input  logic [5:0]  reg_index,
    input  logic [11:0] mem_addr,
    input  logic [63:0] write_value,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [2:0]  status,
    input  logic [63:0] read_value,
    input  logic [63:0] pc_out,
    output int          fails,
    output int          pending,
    output int          checked
);

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] read_value;
        logic [63:0] pc_out;
    } outcome_t;

    logic [63:0] gpr [32];
    logic [63:0] prog_ctr;
    logic [7:0]  mem_bytes [MEM_BYTES];
    logic [2:0]  exit_code;

    outcome_t outcome_q [$];
    int       mismatches;
    int       seen;

    function automatic logic [63:0] sext32(input logic [31:0] v);
        return {{32{v[31]}}, v};
    endfunction

    function automatic logic [2:0] exec_instr(input logic [31:0] ins, input logic ok);
        logic [4:0]  rs;
        logic [4:0]  rt;
        logic [4:0]  rd;
        logic [63:0] ea;
        rs = ins[25:21];
        rt = ins[20:16];
        rd = ins[15:11];
        if (exit_code != ST_OK)
            return ST_HALTED;
        gpr[0] = '0;
        if (!ok)
            return ST_NOEXEC;
        ea = gpr[rs] + {{48{ins[15]}}, ins[15:0]};
        case (ins[31:26])
            OP_LUI:   gpr[rt] = sext32({ins[15:0], 16'h0000});
            OP_ADDIU: gpr[rt] = sext32(ea[31:0]);
            OP_SPECIAL:
            begin
                if (ins[5:0] == FN_OR)
                    gpr[rd] = gpr[rs] | gpr[rt];
                else if (ins[5:0] == FN_AND)
                    gpr[rd] = gpr[rs] & gpr[rt];
                else
                    return ST_BADFN;
            end
            OP_LW:
            begin
                if (ea > 64'(MEM_BYTES - 4))
                    return ST_LOAD;
                gpr[rt] = sext32({mem_bytes[ea], mem_bytes[ea + 1],
                                  mem_bytes[ea + 2], mem_bytes[ea + 3]});
            end
            OP_SW:
            begin
                if (ea > 64'(MEM_BYTES - 4))
                    return ST_STORE;
                mem_bytes[ea]     = gpr[rt][31:24];
                mem_bytes[ea + 1] = gpr[rt][23:16];
                mem_bytes[ea + 2] = gpr[rt][15:8];
                mem_bytes[ea + 3] = gpr[rt][7:0];
            end
            default: return ST_BADOP;
        endcase
        prog_ctr = prog_ctr + 64'd4;
        return ST_OK;
    endfunction

    function automatic outcome_t execute_item(input logic [2:0] f, input logic [31:0] ins,
                                              input logic ok, input logic [5:0] idx,
                                              input logic [11:0] addr,
                                              input logic [63:0] wv);
        outcome_t res;
        res = '0;
        case (f)
            FUNC_EXEC:
            begin
                res.status = exec_instr(ins, ok);
                if (res.status != ST_OK && res.status != ST_HALTED)
                    exit_code = res.status;
            end
            FUNC_WREG:
            begin
                if (idx < PC_INDEX)
                    gpr[idx[4:0]] = wv;
                else if (idx == PC_INDEX)
                    prog_ctr = wv;
            end
            FUNC_RREG:
            begin
                if (idx < PC_INDEX)
                    res.read_value = gpr[idx[4:0]];
                else if (idx == PC_INDEX)
                    res.read_value = prog_ctr;
            end
            FUNC_WMEM:
            begin
                if (addr < MEM_BYTES)
                    mem_bytes[addr] = wv[7:0];
            end
            FUNC_RMEM:
            begin
                if (addr < MEM_BYTES)
                    res.read_value = {56'd0, mem_bytes[addr]};
            end
            default: ;
        endcase
        res.pc_out = prog_ctr;
        return res;
    endfunction

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        mismatches++;
        $display("mismatch %0d: %s got %h expected %h", mismatches, what, got, want);
    endtask

    task automatic check_field(input string what, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report(what, got, want);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        outcome_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < 32; i++)
                gpr[i] = '0;
            for (int i = 0; i < MEM_BYTES; i++)
                mem_bytes[i] = '0;
            prog_ctr = '0;
            exit_code = ST_OK;
            outcome_q.delete();
            mismatches = 0;
            seen = 0;
            fails <= 0;
            pending <= 0;
            checked <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (outcome_q.size() == 0)
                    report("result with no transaction waiting, status", 64'(status), '0);
                else
                begin
                    want = outcome_q.pop_front();
                    check_field("status", 64'(status), 64'(want.status));
                    check_field("read_value", read_value, want.read_value);
                    check_field("pc_out", pc_out, want.pc_out);
                end
                seen++;
            end
            if (in_valid && in_ready)
                outcome_q.push_back(execute_item(func, instr, exec_ok, reg_index,
                                                 mem_addr, write_value));
            fails <= mismatches;
            pending <= outcome_q.size();
            checked <= seen;
        end
    end

endmodule

>>> tb/testbench.sv
module testbench;
    import m64x_pkg::*;

    localparam int MEM_BYTES     = 4096;
    localparam int CYCLE_LIMIT   = 800000;
    localparam int RANDOM_ITEMS  = 1150;
    localparam int PRELOAD_BYTES = 256;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [2:0]  func = '0;
    logic [31:0] instr = '0;
    logic        exec_ok = 1'b0;
    logic [5:0]  reg_index = '0;
    logic [11:0] mem_addr = '0;
    logic [63:0] write_value = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  status;
    logic [63:0] read_value;
    logic [63:0] pc_out;

    int fails;
    int pending;
    int checked;
    int cycles = 0;
    int sent = 0;
    int execs = 0;
    bit quiet = 1'b0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    mips64_subset_execute_unit #(
        .MEM_BYTES (MEM_BYTES)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .func        (func),
        .instr       (instr),
        .exec_ok     (exec_ok),
        .reg_index   (reg_index),
        .mem_addr    (mem_addr),
        .write_value (write_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .read_value  (read_value),
        .pc_out      (pc_out)
    );

    m64x_exec_check #(
        .MEM_BYTES (MEM_BYTES)
    ) u_exec_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .func        (func),
        .instr       (instr),
        .exec_ok     (exec_ok),
        .reg_index   (reg_index),
        .mem_addr    (mem_addr),
        .write_value (write_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .read_value  (read_value),
        .pc_out      (pc_out),
        .fails       (fails),
        .pending     (pending),
        .checked     (checked)
    );

    always @(posedge clk)
    begin
        out_ready <= quiet || ($urandom_range(0, 99) >= 9);
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    function automatic logic [63:0] rand_word();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return 64'h8000_0000_0000_0000;
            3: return {32'd0, $urandom};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [5:0] rand_index();
        case ($urandom_range(0, 9))
            0: return PC_INDEX;
            1: return 6'($urandom_range(33, 63));
            default: return 6'($urandom_range(0, 31));
        endcase
    endfunction

    task automatic send(input logic [2:0] f, input logic [31:0] ins, input logic ok,
                        input logic [5:0] idx, input logic [11:0] addr,
                        input logic [63:0] wv);
        int gap;
        gap = 0;
        if (!quiet && $urandom_range(0, 99) < 9)
            gap = $urandom_range(1, 12);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        func <= f;
        instr <= ins;
        exec_ok <= ok;
        reg_index <= idx;
        mem_addr <= addr;
        write_value <= wv;
        do @(posedge clk); while (!in_ready);
        sent++;
        if (f == FUNC_EXEC)
            execs++;
    endtask

    // Loads the base register so that base + offset lands on target, then issues LW or SW.
    task automatic word_access(input bit store, input logic [63:0] target);
        logic [31:0] r;
        logic [4:0]  base;
        logic [15:0] off;
        logic [63:0] base_val;
        r = $urandom;
        off = r[15:0];
        if (target < 64'h8000 && $urandom_range(0, 3) == 0)
        begin
            // junk in R0; the instruction must clear it before use
            base = 5'd0;
            off = target[15:0];
            base_val = rand_word();
        end
        else
        begin
            base = 5'($urandom_range(1, 31));
            base_val = target - {{48{off[15]}}, off};
        end
        send(FUNC_WREG, $urandom, 1'($urandom), {1'b0, base}, 12'($urandom), base_val);
        send(FUNC_EXEC, {(store ? OP_SW : OP_LW), base, r[20:16], off}, 1'b1,
             6'($urandom), 12'($urandom), rand_word());
    endtask

    initial
    begin
        logic [31:0] r;
        logic [5:0]  op;
        logic [5:0]  fn;
        logic [63:0] tgt;
        int          fault_kind;
        string       fault_name;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // random loads and byte reads stay inside this written window
        for (int a = 0; a < PRELOAD_BYTES; a++)
            send(FUNC_WMEM, $urandom, 1'($urandom), 6'($urandom), 12'(a), rand_word());

        send(FUNC_RREG, '0, 1'b0, 6'd5, '0, '0);
        send(FUNC_RREG, '0, 1'b0, PC_INDEX, '0, '0);
        send(FUNC_WREG, '0, 1'b0, PC_INDEX, '0, 64'hFFFF_FFFF_FFFF_FFF8);
        send(FUNC_EXEC, {OP_LUI, 5'd0, 5'd1, 16'h8000}, 1'b1, '0, '0, '0);
        send(FUNC_EXEC, {OP_LUI, 5'd31, 5'd2, 16'h7FFF}, 1'b1, '0, '0, '0);
        send(FUNC_EXEC, {OP_ADDIU, 5'd1, 5'd3, 16'hFFFF}, 1'b1, '0, '0, '0);
        send(FUNC_EXEC, {OP_ADDIU, 5'd2, 5'd4, 16'h7FFF}, 1'b1, '0, '0, '0);
        send(FUNC_EXEC, {OP_SPECIAL, 5'd3, 5'd4, 5'd5, 5'h1F, FN_OR}, 1'b1, '0, '0, '0);
        send(FUNC_EXEC, {OP_SPECIAL, 5'd1, 5'd3, 5'd6, 5'h00, FN_AND}, 1'b1, '0, '0, '0);
        send(FUNC_WREG, '0, 1'b0, 6'd0, '0, '1);
        send(FUNC_RREG, '0, 1'b0, 6'd0, '0, '0);
        send(FUNC_EXEC, {OP_SPECIAL, 5'd0, 5'd0, 5'd7, 5'h00, FN_OR}, 1'b1, '0, '0, '0);
        send(FUNC_RREG, '0, 1'b0, 6'd0, '0, '0);
        word_access(1'b1, 64'd0);
        word_access(1'b0, 64'd0);
        word_access(1'b1, 64'(MEM_BYTES - 4));
        word_access(1'b0, 64'(MEM_BYTES - 4));
        send(FUNC_WMEM, '0, 1'b0, '0, 12'hFFF, '1);
        send(FUNC_RMEM, '0, 1'b0, '0, 12'hFFF, '0);
        send(FUNC_WREG, '0, 1'b0, 6'd63, '0, '1);
        send(FUNC_RREG, '0, 1'b0, 6'd63, '0, '0);
        for (int f = 5; f <= 7; f++)
            send(3'(f), '1, 1'b1, 6'd1, 12'd1, '1);
        send(FUNC_RREG, '0, 1'b0, PC_INDEX, '0, '0);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            quiet = (n >= 400 && n < 650);
            r = $urandom;
            case ($urandom_range(0, 99)) inside
                [0:19]:  word_access(1'b0, 64'($urandom_range(0, PRELOAD_BYTES - 4)));
                [20:34]: word_access(1'b1, 64'($urandom_range(0, PRELOAD_BYTES - 4)));
                [35:46]: send(FUNC_EXEC, {OP_LUI, r[25:0]}, 1'b1, 6'($urandom),
                              12'($urandom), rand_word());
                [47:58]: send(FUNC_EXEC, {OP_ADDIU, r[25:0]}, 1'b1, 6'($urandom),
                              12'($urandom), rand_word());
                [59:68]: send(FUNC_EXEC, {OP_SPECIAL, r[25:6], (r[31] ? FN_OR : FN_AND)},
                              1'b1, 6'($urandom), 12'($urandom), rand_word());
                [69:78]: send(FUNC_WREG, $urandom, 1'($urandom), rand_index(),
                              12'($urandom), rand_word());
                [79:88]: send(FUNC_RREG, $urandom, 1'($urandom), rand_index(),
                              12'($urandom), rand_word());
                [89:93]: send(FUNC_WMEM, $urandom, 1'($urandom), 6'($urandom),
                              12'($urandom), rand_word());
                [94:97]: send(FUNC_RMEM, $urandom, 1'($urandom), 6'($urandom),
                              12'($urandom_range(0, PRELOAD_BYTES - 1)), rand_word());
                default: send(3'($urandom_range(5, 7)), $urandom, 1'($urandom),
                              6'($urandom), 12'($urandom), rand_word());
            endcase
        end
        quiet = 1'b0;

        // exit code is sticky until reset, so one fault kind per run
        fault_kind = $urandom_range(0, 4);
        r = $urandom;
        case (fault_kind)
            0:
            begin
                fault_name = "no exec permission";
                send(FUNC_EXEC, $urandom, 1'b0, 6'($urandom), 12'($urandom), rand_word());
            end
            1:
            begin
                fault_name = "invalid opcode";
                do op = 6'($urandom);
                while (op inside {OP_SPECIAL, OP_ADDIU, OP_LUI, OP_LW, OP_SW});
                send(FUNC_EXEC, {op, r[25:0]}, 1'b1, 6'($urandom), 12'($urandom),
                     rand_word());
            end
            2:
            begin
                fault_name = "bad special function";
                do fn = 6'($urandom);
                while (fn == FN_OR || fn == FN_AND);
                send(FUNC_EXEC, {OP_SPECIAL, r[25:6], fn}, 1'b1, 6'($urandom),
                     12'($urandom), rand_word());
            end
            default:
            begin
                fault_name = (fault_kind == 3) ? "load out of memory" : "store out of memory";
                if ($urandom_range(0, 1))
                    tgt = 64'(MEM_BYTES - $urandom_range(1, 3));
                else
                    tgt = rand_word() | (64'h1 << $urandom_range(12, 63));
                word_access(fault_kind == 4, tgt);
            end
        endcase

        send(FUNC_WREG, '0, 1'b0, 6'd0, '0, 64'hA5A5_5A5A_0F0F_F0F0);
        send(FUNC_EXEC, {OP_SPECIAL, 5'd0, 5'd0, 5'd8, 5'h00, FN_OR}, 1'b1, '0, '0, '0);
        send(FUNC_RREG, '0, 1'b0, 6'd0, '0, '0);
        for (int n = 0; n < 40; n++)
        begin
            case ($urandom_range(0, 5))
                0, 1, 2: send(FUNC_EXEC, $urandom, 1'($urandom), rand_index(),
                              12'($urandom), rand_word());
                3:       send(FUNC_WREG, $urandom, 1'($urandom), rand_index(),
                              12'($urandom), rand_word());
                4:       send(FUNC_RREG, $urandom, 1'($urandom), rand_index(),
                              12'($urandom), rand_word());
                default: send(FUNC_RMEM, $urandom, 1'($urandom), rand_index(),
                              12'($urandom_range(0, PRELOAD_BYTES - 1)), rand_word());
            endcase
        end
        in_valid <= 1'b0;

        do @(posedge clk); while (pending != 0);
        repeat (30) @(posedge clk);

        $display("testbench: %0d transactions sent (%0d executes) after a %0d-byte preload",
                 sent, execs, PRELOAD_BYTES);
        $display("testbench: %0d results checked; fault taken: %s, then halted traffic",
                 checked, fault_name);
        if (fails == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl
rtl/m64x_pkg.sv
rtl/m64x_datapath.sv
rtl/m64x_ctrl.sv
rtl/mips64_subset_execute_unit.sv
tb/m64x_exec_check.sv
tb/testbench.sv
